// File: rtl/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types and constants for the boot record parser.
// ----------------------------------------------------------------------------
package brp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READY  = 2'd1;
    localparam logic [1:0] KIND_RESEND = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // Framing characters
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DONE  = 8'h53;

    // Offset of the relocated boot vector in word mode
    localparam logic [15:0] VECTOR_OFFSET = 16'd4;

    // Configuration register indexes
    localparam logic [7:0] CFG_MOVED_START = 8'd0;
    localparam logic [7:0] CFG_BYTE_MODE   = 8'd1;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [15:0] start;
        logic        byte_mode;
    } cfg_t;

    // Record command handed from the parser to the writer
    typedef struct packed {
        logic [1:0]  kind;   // reply kind that closes the command
        logic [7:0]  len;    // data bytes in the buffer (0 for no writes)
        logic [15:0] base;   // first word write address
    } cmd_t;

endpackage

// File: rtl/brp_ram.sv
// ----------------------------------------------------------------------------
// brp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/brp_front.sv
// ----------------------------------------------------------------------------
// brp_front
// Record parser: frames received bytes, fills the record buffer, checks the
// checksum and posts one command per finished record, done marker or oversize length.
// ----------------------------------------------------------------------------
module brp_front #(
    parameter int MAX_RECORD = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [7:0]                    rx_byte,
    output logic                          full,
    input  brp_pkg::cfg_t                 cfg,
    input  logic                          cmd_full,
    output logic                          cmd_push,
    output brp_pkg::cmd_t                 cmd_out,
    output logic                          ram_we,
    output logic [$clog2(MAX_RECORD)-1:0] ram_waddr,
    output logic [7:0]                    ram_wdata,
    input  logic                          buf_release,
    output logic                          buf_busy
);

    localparam int AW = $clog2(MAX_RECORD);
    localparam int CW = $clog2(MAX_RECORD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_RECORD);

    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_ADDR_HI = 3'd2;
    localparam logic [2:0] PH_ADDR_LO = 3'd3;
    localparam logic [2:0] PH_SUM     = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] len_reg, len_next;
    logic [15:0]   addr_reg, addr_next;
    logic [7:0]    sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic          finished_reg, finished_next;
    logic          busy_reg, busy_next;

    logic          accept;
    logic          buf_set;
    logic [15:0]   doubled;
    logic [15:0]   base;

    // Stall every byte while the command queue is full, and data bytes while the writer still owns the buffer
    assign full     = cmd_full || (phase_reg == PH_DATA && busy_reg);
    assign accept   = push && !full;
    assign buf_busy = busy_reg;
    assign ram_wdata = rx_byte;

    // First write address, with address zero moved to the boot vector
    always_comb
    begin
        doubled = cfg.byte_mode ? {addr_reg[14:0], 1'b0} : addr_reg;
        if (doubled == 16'd0)
        begin
            base = cfg.byte_mode ? cfg.start : cfg.start + brp_pkg::VECTOR_OFFSET;
        end
        else
        begin
            base = doubled;
        end
    end

    // Parse one item
    always_comb
    begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        addr_next     = addr_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        cmd_push      = 1'b0;
        cmd_out.kind  = brp_pkg::KIND_RESEND;
        cmd_out.len   = 8'd0;
        cmd_out.base  = base;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        buf_set       = 1'b0;
        if (accept && !finished_reg)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == brp_pkg::CHAR_COLON)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte == brp_pkg::CHAR_DONE)
                    begin
                        cmd_push      = 1'b1;
                        cmd_out.kind  = brp_pkg::KIND_DONE;
                        finished_next = 1'b1;
                        phase_next    = PH_WAIT;
                    end
                    else if (rx_byte > MAX_LEN)
                    begin
                        cmd_push     = 1'b1;
                        cmd_out.kind = brp_pkg::KIND_RESEND;
                        phase_next   = PH_WAIT;
                    end
                    else
                    begin
                        len_next   = rx_byte[CW-1:0];
                        sum_next   = rx_byte;
                        phase_next = PH_ADDR_HI;
                    end
                end
                PH_ADDR_HI:
                begin
                    addr_next  = {rx_byte, 8'h00};
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_ADDR_LO;
                end
                PH_ADDR_LO:
                begin
                    addr_next  = {addr_reg[15:8], rx_byte};
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    sum_next   = sum_reg + rx_byte;
                    count_next = '0;
                    if (len_reg == '0)
                    begin
                        cmd_push     = 1'b1;
                        cmd_out.kind = (sum_next == 8'd0) ? brp_pkg::KIND_READY
                                                          : brp_pkg::KIND_RESEND;
                        phase_next   = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    ram_we     = 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_reg + 1'b1;
                    if (count_next >= len_reg)
                    begin
                        cmd_push   = 1'b1;
                        phase_next = PH_WAIT;
                        if (sum_next == 8'd0)
                        begin
                            cmd_out.kind = brp_pkg::KIND_READY;
                            cmd_out.len  = 8'(len_reg);
                            buf_set      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    // Buffer ownership: taken by a good record, returned by the writer
    always_comb
    begin
        busy_next = busy_reg;
        if (buf_release)
        begin
            busy_next = 1'b0;
        end
        if (buf_set)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT;
            len_reg      <= '0;
            addr_reg     <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            addr_reg     <= addr_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

// File: rtl/brp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// brp_cmd_fifo
// Two-entry command queue between the parser and the writer.
// ----------------------------------------------------------------------------
module brp_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  brp_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output brp_pkg::cmd_t head,
    output logic          empty
);

    brp_pkg::cmd_t entry_reg [2];
    logic [1:0]    count_reg, count_next;
    logic          wptr_reg;
    logic          rptr_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = entry_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Store items
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

endmodule

// File: rtl/brp_back.sv
// ----------------------------------------------------------------------------
// brp_back
// Record writer: turns commands into word writes read from the record
// buffer, then the reply, through a one-item result register.
// ----------------------------------------------------------------------------
module brp_back #(
    parameter int MAX_RECORD = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brp_pkg::cfg_t                 cfg,
    input  logic                          cmd_empty,
    input  brp_pkg::cmd_t                 cmd_head,
    output logic                          cmd_pop,
    output logic                          ram_re,
    output logic [$clog2(MAX_RECORD)-1:0] ram_raddr,
    input  logic [7:0]                    ram_rdata,
    output logic                          buf_release,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    kind,
    output logic [15:0]                   write_address,
    output logic [15:0]                   write_word,
    output logic                          last
);

    localparam int AW = $clog2(MAX_RECORD);
    localparam int IW = $clog2(MAX_RECORD + 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HI    = 3'd1;
    localparam logic [2:0] ST_LO    = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_REPLY = 3'd4;

    logic [2:0]    st_reg, st_next;
    brp_pkg::cmd_t cmd_reg, cmd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   addr_reg, addr_next;
    logic [7:0]    hi_reg, hi_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [15:0]   waddr_reg, waddr_next;
    logic [15:0]   wword_reg, wword_next;
    logic          last_reg, last_next;

    logic          can_load;
    logic [IW-1:0] idx1;
    logic [IW-1:0] idx2;
    logic          has_lo;
    logic          more;
    logic [15:0]   step;

    assign empty         = !out_valid_reg;
    assign kind          = kind_reg;
    assign write_address = waddr_reg;
    assign write_word    = wword_reg;
    assign last          = last_reg;

    assign can_load = !out_valid_reg || pop;
    assign idx1     = idx_reg + 1'b1;
    assign idx2     = idx_reg + 2'd2;
    assign has_lo   = 8'(idx1) < cmd_reg.len;
    assign more     = 8'(idx2) < cmd_reg.len;
    assign step     = cfg.byte_mode ? 16'd2 : 16'd1;

    // Sequence the writes of one command
    always_comb
    begin
        st_next        = st_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = kind_reg;
        waddr_next     = waddr_reg;
        wword_next     = wword_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];
        buf_release    = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd_head;
                    addr_next = cmd_head.base;
                    idx_next  = '0;
                    if (cmd_head.kind == brp_pkg::KIND_READY && cmd_head.len != 8'd0)
                    begin
                        st_next = ST_HI;
                    end
                    else
                    begin
                        st_next = ST_REPLY;
                    end
                end
            end
            ST_HI:
            begin
                ram_re  = 1'b1;
                st_next = ST_LO;
            end
            ST_LO:
            begin
                hi_next   = ram_rdata;
                ram_raddr = idx1[AW-1:0];
                ram_re    = has_lo;
                st_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = brp_pkg::KIND_WRITE;
                    waddr_next     = addr_reg;
                    wword_next     = {hi_reg, has_lo ? ram_rdata : 8'h00};
                    last_next      = 1'b0;
                    addr_next      = addr_reg + step;
                    idx_next       = idx2;
                    st_next        = more ? ST_HI : ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = cmd_reg.kind;
                    waddr_next     = 16'd0;
                    wword_next     = 16'd0;
                    last_next      = 1'b1;
                    buf_release    = (cmd_reg.kind == brp_pkg::KIND_READY)
                                     && (cmd_reg.len != 8'd0);
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        addr_reg  <= addr_next;
        hi_reg    <= hi_next;
        kind_reg  <= kind_next;
        waddr_reg <= waddr_next;
        wword_reg <= wword_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/boot_record_parser_core.sv
// ----------------------------------------------------------------------------
// boot_record_parser_core
// Serial boot record parser with checksum, emitting program word writes.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock while full is low as it frames
// a record, and posts each finished record to a two-entry command queue. The
// writer then emits each word write through ST_HI, ST_LO and ST_EMIT, using
// the single read port of the record buffer (up to two reads per word),
// followed by the reply; done and resend replies go straight from ST_IDLE to
// ST_REPLY. Data bytes of the next record stall (full high) until the writer
// has drained the buffer of the previous good record. Header bytes of the
// next record are taken meanwhile.
module boot_record_parser_core #(
    parameter int MAX_RECORD = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] write_address,
    output logic [15:0] write_word,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(MAX_RECORD);

    logic [15:0]   start_reg;
    logic          mode_reg;
    brp_pkg::cfg_t cfg;

    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    brp_pkg::cmd_t cmd_in;
    brp_pkg::cmd_t cmd_head;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          buf_release;
    logic          buf_busy;

    assign cfg_ready     = 1'b1;
    assign cfg.start     = start_reg;
    assign cfg.byte_mode = mode_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 16'd0;
            mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brp_pkg::CFG_MOVED_START: start_reg <= cfg_data;
                brp_pkg::CFG_BYTE_MODE:   mode_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    brp_front #(
        .MAX_RECORD (MAX_RECORD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .rx_byte     (rx_byte),
        .full        (full),
        .cfg         (cfg),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_out     (cmd_in),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .buf_release (buf_release),
        .buf_busy    (buf_busy)
    );

    brp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RECORD)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brp_cmd_fifo u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .empty    (cmd_empty)
    );

    brp_back #(
        .MAX_RECORD (MAX_RECORD)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd_empty     (cmd_empty),
        .cmd_head      (cmd_head),
        .cmd_pop       (cmd_pop),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .buf_release   (buf_release),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .write_address (write_address),
        .write_word    (write_word),
        .last          (last)
    );

`ifndef ASSERT_OFF
    // The parser never posts a command into a full queue
    a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");

    // The writer only hands back a buffer the parser gave it
    a_release_owned: assert property (@(posedge clk) disable iff (!rst_n)
        buf_release |-> buf_busy)
        else $error("buffer released while not owned");

    // The parser never overwrites a buffer the writer still reads
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !buf_busy)
        else $error("record buffer written while busy");

    // A word write is never the final result of an item
    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == brp_pkg::KIND_WRITE) |-> !last)
        else $error("word write marked last");
`endif

endmodule

// File: verif/boot_record_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_record_parser_core_tb
// Drives serial bytes into the boot record parser and checks every word
// write and reply against a cycle-free model of the framing, checksum and
// address remapping. Byte and result sides both idle at random. The
// configuration is changed between phases while the parser is quiet.
// ----------------------------------------------------------------------------
module boot_record_parser_core_tb;

    localparam int MAX_RECORD = 16;

    typedef enum logic [2:0] {
        SEEK_COLON,
        TAKE_LEN,
        TAKE_ADDR_HI,
        TAKE_ADDR_LO,
        TAKE_SUM,
        TAKE_DATA
    } frame_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [15:0] word;
        logic        last;
    } parser_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [15:0] write_address;
    logic [15:0] write_word;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = brp_pkg::CFG_MOVED_START;
    logic [15:0] cfg_data = 16'h0000;

    // Model of the parser state and configuration
    frame_phase_t phase = SEEK_COLON;
    logic [4:0]   rec_len = '0;
    logic [15:0]  rec_addr = '0;
    logic [7:0]   rec_sum = '0;
    logic [4:0]   byte_cnt = '0;
    logic [7:0]   rec_bytes [MAX_RECORD];
    logic         finished = 1'b0;
    logic [15:0]  vec_start = '0;
    logic         byte_mode = 1'b0;

    parser_result_t record_outputs[$];
    int  mismatches = 0;
    int  framed_items = 0;
    bit  no_idle = 1'b0;
    int  hold_left = 0;

    boot_record_parser_core #(
        .MAX_RECORD(MAX_RECORD)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .write_address (write_address),
        .write_word    (write_word),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pick an idle span: mostly none or short, now and then long
    function automatic int idle_span();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void post_result(input logic [1:0] k, input logic [15:0] a,
                                        input logic [15:0] w);
        parser_result_t res;
        res.kind    = k;
        res.address = a;
        res.word    = w;
        res.last    = 1'b0;
        record_outputs.push_back(res);
    endfunction

    // Close a record: word writes and ready when the sum is zero, else resend
    function automatic void close_record();
        logic [15:0] addr;
        logic [15:0] step;
        logic [7:0]  lo;
        if (rec_sum == 8'h00)
        begin
            addr = byte_mode ? {rec_addr[14:0], 1'b0} : rec_addr;
            step = byte_mode ? 16'd2 : 16'd1;
            if (addr == 16'h0000)
                addr = byte_mode ? vec_start : vec_start + brp_pkg::VECTOR_OFFSET;
            for (int k = 0; k < rec_len; k += 2)
            begin
                lo = (k + 1 < rec_len) ? rec_bytes[k + 1] : 8'h00;
                post_result(brp_pkg::KIND_WRITE, addr, {rec_bytes[k], lo});
                addr = addr + step;
            end
            post_result(brp_pkg::KIND_READY, 16'h0000, 16'h0000);
        end
        else
        begin
            post_result(brp_pkg::KIND_RESEND, 16'h0000, 16'h0000);
        end
        phase = SEEK_COLON;
    endfunction

    // Advance the framing model by one accepted byte
    function automatic void frame_rx_byte(input logic [7:0] b);
        int before_cnt;
        before_cnt = record_outputs.size();
        if (finished)
            return;
        case (phase)
            SEEK_COLON:
            begin
                if (b == brp_pkg::CHAR_COLON)
                    phase = TAKE_LEN;
            end
            TAKE_LEN:
            begin
                if (b == brp_pkg::CHAR_DONE)
                begin
                    post_result(brp_pkg::KIND_DONE, 16'h0000, 16'h0000);
                    finished = 1'b1;
                    phase = SEEK_COLON;
                end
                else if (b > MAX_RECORD)
                begin
                    post_result(brp_pkg::KIND_RESEND, 16'h0000, 16'h0000);
                    phase = SEEK_COLON;
                end
                else
                begin
                    rec_len = b[4:0];
                    rec_sum = b;
                    phase = TAKE_ADDR_HI;
                end
            end
            TAKE_ADDR_HI:
            begin
                rec_addr = {b, 8'h00};
                rec_sum = rec_sum + b;
                phase = TAKE_ADDR_LO;
            end
            TAKE_ADDR_LO:
            begin
                rec_addr = {rec_addr[15:8], b};
                rec_sum = rec_sum + b;
                phase = TAKE_SUM;
            end
            TAKE_SUM:
            begin
                rec_sum = rec_sum + b;
                byte_cnt = '0;
                if (rec_len == 0)
                    close_record();
                else
                    phase = TAKE_DATA;
            end
            default:
            begin
                if (byte_cnt < MAX_RECORD)
                    rec_bytes[byte_cnt] = b;
                rec_sum = rec_sum + b;
                byte_cnt = byte_cnt + 1'b1;
                if (byte_cnt >= rec_len)
                    close_record();
            end
        endcase
        if (record_outputs.size() > before_cnt)
            record_outputs[record_outputs.size() - 1].last = 1'b1;
    endfunction

    // Send one byte; push stays high so a following byte can go back to back
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_span();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!finished && (phase != SEEK_COLON || b == brp_pkg::CHAR_COLON))
            framed_items++;
        frame_rx_byte(b);
    endtask

    // Frame a record with random data and a good or broken checksum
    task automatic send_record(input logic [4:0] len, input logic [15:0] addr,
                               input bit good);
        logic [7:0] data [MAX_RECORD];
        logic [7:0] acc;
        logic [7:0] cks;
        acc = {3'b000, len} + addr[15:8] + addr[7:0];
        for (int i = 0; i < len; i++)
        begin
            data[i] = 8'($urandom);
            acc = acc + data[i];
        end
        cks = 8'h00 - acc;
        if (!good)
            cks = cks + 8'($urandom_range(1, 255));
        send_byte(brp_pkg::CHAR_COLON);
        send_byte({3'b000, len});
        send_byte(addr[15:8]);
        send_byte(addr[7:0]);
        send_byte(cks);
        for (int i = 0; i < len; i++)
            send_byte(data[i]);
    endtask

    // Close any open record, drop push, drain results and let the writer settle
    task automatic settle();
        while (!finished && phase != SEEK_COLON)
            send_byte(phase == TAKE_LEN ? 8'hFF : 8'h00);
        push <= 1'b0;
        while (record_outputs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write both registers; valid stays high across the two items
    task automatic set_config(input logic [15:0] start, input logic mode);
        cfg_valid <= 1'b1;
        cfg_index <= brp_pkg::CFG_MOVED_START;
        cfg_data  <= start;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        vec_start = start;
        cfg_index <= brp_pkg::CFG_BYTE_MODE;
        cfg_data  <= {15'h0000, mode};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        byte_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    // Noise, remapped odd record, empty record, oversize length, bad sum
    task automatic test_framing_cases();
        logic [7:0] seq [22] = '{
            8'h00, 8'hFF,
            brp_pkg::CHAR_COLON, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF,
            brp_pkg::CHAR_COLON, 8'h00, 8'hFF, 8'hFF, 8'h02,
            brp_pkg::CHAR_COLON, 8'h11,
            brp_pkg::CHAR_COLON, 8'h02, 8'h12, 8'h34, 8'h7F, brp_pkg::CHAR_COLON, 8'h00
        };
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Random mix of records, mostly well formed, under the current settings
    task automatic test_random_records(input int budget, input bit quiet_phase);
        int target;
        int r;
        logic [4:0]  len;
        logic [15:0] addr;
        logic [7:0]  oversize;
        target = framed_items + budget;
        while (framed_items < target)
        begin
            no_idle = quiet_phase || ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? 5'd16 :
                  ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 15));
            case ($urandom_range(0, 9))
                0, 1:    addr = 16'h0000;
                2:       addr = 16'hFFFF;
                3:       addr = 16'h8000;
                default: addr = 16'($urandom);
            endcase
            if (r < 80)
            begin
                send_record(len, addr, r < 70);
            end
            else if (r < 87)
            begin
                oversize = 8'($urandom_range(MAX_RECORD + 1, 255));
                if (oversize == brp_pkg::CHAR_DONE)
                    oversize = oversize + 1'b1;
                send_byte(brp_pkg::CHAR_COLON);
                send_byte(oversize);
            end
            else if (r < 94)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            else
            begin
                // truncated record: the next colon lands inside its header or data
                send_byte(brp_pkg::CHAR_COLON);
                send_byte({3'b000, len});
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // Step through settings, extremes first, with a random phase under each
    task automatic test_config_sweep();
        logic [15:0] starts [5] = '{16'h0000, 16'hFFFF, 16'hFFFC, 16'h8000, 16'h0000};
        logic        modes  [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        starts[4] = 16'($urandom);
        modes[4]  = 1'($urandom);
        for (int i = 0; i < 5; i++)
        begin
            settle();
            set_config(starts[i], modes[i]);
            test_random_records(20, i == 2);
        end
    endtask

    // Done marker, then bytes that must all be ignored
    task automatic test_done_marker();
        settle();
        send_byte(brp_pkg::CHAR_COLON);
        send_byte(brp_pkg::CHAR_DONE);
        send_byte(brp_pkg::CHAR_COLON);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(brp_pkg::CHAR_COLON);
        send_byte(brp_pkg::CHAR_DONE);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 50)
                $display("%0t ns: %s mismatch: expected %h, actual %h",
                         $time, field, want, got);
        end
    endtask

    // Drive pop with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
        begin
            pop <= 1'b1;
            hold_left = idle_span();
        end
    end

    // Check each accepted result against the oldest one due
    always @(posedge clk)
    begin
        parser_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (record_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $display("%0t ns: unexpected result: expected none, actual kind %0d",
                             $time, kind);
            end
            else
            begin
                want = record_outputs.pop_front();
                check_field("kind", {14'h0000, want.kind}, {14'h0000, kind});
                check_field("write_address", want.address, write_address);
                check_field("write_word", want.word, write_word);
                check_field("last", {15'h0000, want.last}, {15'h0000, last});
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_framing_cases();
        test_config_sweep();
        test_done_marker();
        push <= 1'b0;
        while (record_outputs.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && record_outputs.size() == 0)
            $display("boot_record_parser_core_tb: done, clean");
        else
            $display("boot_record_parser_core_tb: done, errors");
        $finish;
    end

    // Hard stop on a hang
    initial
    begin
        #20000000;
        $display("boot_record_parser_core_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/brp_pkg.sv
rtl/brp_ram.sv
rtl/brp_front.sv
rtl/brp_cmd_fifo.sv
rtl/brp_back.sv
rtl/boot_record_parser_core.sv
verif/boot_record_parser_core_tb.sv
